### sv/reqt_pkg.sv
`default_nettype none
package reqt_pkg;

  // table geometry
  localparam int MAX_REPLICAS = 16;
  localparam int IDX_W        = $clog2(MAX_REPLICAS);
  localparam int CNT_W        = $clog2(MAX_REPLICAS + 1);
  localparam int EPOCH_W      = 64;

  // register widths
  localparam int RC_W  = 5;
  localparam int FC_W  = 3;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 2;

  // stream widths (fields packed from bit 0, padded to bytes)
  localparam int IN_W  = 72;
  localparam int OUT_W = 136;

  // command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } reqt_op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPLICA_COUNT = 2'd0,
    REG_FAULT_COUNT   = 2'd1,
    REG_READ_ONLY     = 2'd2,
    REG_NONE          = 2'd3
  } reqt_reg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } reqt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // capture word, apply write, restart scan
    logic step;      // issue next candidate
    logic load_out;  // move result into output register
  } reqt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;  // all candidates issued and folded in
  } reqt_sts_t;

endpackage
`default_nettype wire

### sv/reqt_dp.sv
`default_nettype none
module reqt_dp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [reqt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [reqt_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [reqt_pkg::IN_W-1:0]      in_word,
  input  wire reqt_pkg::reqt_cmd_t            cmd,
  output      reqt_pkg::reqt_sts_t            sts,
  output      logic [reqt_pkg::OUT_W-1:0]     out_word
);
  import reqt_pkg::*;

  logic [RC_W-1:0]    replica_count;
  logic [FC_W-1:0]    fault_count;
  logic               read_only;

  logic [EPOCH_W-1:0] epoch_table [MAX_REPLICAS];
  logic [IDX_W-1:0]   idx;

  logic [CNT_W-1:0]   cnt;
  logic               p_valid;
  logic [EPOCH_W-1:0] cand;
  logic [MAX_REPLICAS-1:0] eqv;
  logic               found;
  logic [EPOCH_W-1:0] best;

  logic [CNT_W-1:0]   n_eff;
  logic [FC_W:0]      need;
  logic               cnt_lt_n;
  logic [MAX_REPLICAS-1:0] eq_now;
  logic [CNT_W-1:0]   hits;

  logic               in_cmd;
  logic [IDX_W-1:0]   in_idx;
  logic [EPOCH_W-1:0] in_epoch;

  assign in_cmd   = in_word[0];
  assign in_idx   = in_word[IDX_W:1];
  assign in_epoch = in_word[IDX_W+EPOCH_W:IDX_W+1];

  // replica count saturates at table size; quorum is 2f+1
  always_comb begin
    if (replica_count > RC_W'(MAX_REPLICAS)) begin
      n_eff = CNT_W'(MAX_REPLICAS);
    end else begin
      n_eff = CNT_W'(replica_count);
    end
    need     = {fault_count, 1'b1};
    cnt_lt_n = cnt < n_eff;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      replica_count <= RC_W'(4);
      fault_count   <= FC_W'(1);
      read_only     <= 1'b0;
    end else if (cfg_we) begin
      case (reqt_reg_t'(cfg_index))
        REG_REPLICA_COUNT: replica_count <= cfg_data[RC_W-1:0];
        REG_FAULT_COUNT:   fault_count   <= cfg_data[FC_W-1:0];
        REG_READ_ONLY:     read_only     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // epoch table, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_REPLICAS; i++) begin
        epoch_table[i] <= '0;
      end
    end else if (cmd.start && reqt_op_t'(in_cmd) == CMD_WRITE && !read_only) begin
      epoch_table[in_idx] <= in_epoch;
    end
  end

  // candidate against every entry, masked to the counted replicas
  always_comb begin
    for (int j = 0; j < MAX_REPLICAS; j++) begin
      eq_now[j] = (epoch_table[j] == epoch_table[cnt[IDX_W-1:0]]) &&
                  (CNT_W'(j) < n_eff);
    end
  end

  // popcount of the registered match vector
  always_comb begin
    hits = '0;
    for (int j = 0; j < MAX_REPLICAS; j++) begin
      hits = hits + CNT_W'(eqv[j]);
    end
  end

  // scan: stage 1 issues a candidate, stage 2 folds it into the minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
      best    <= '0;
    end else if (cmd.start) begin
      cnt     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
      best    <= '0;
    end else begin
      p_valid <= cmd.step && cnt_lt_n;
      if (cmd.step && cnt_lt_n) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (p_valid && (hits >= CNT_W'(need)) && (!found || cand < best)) begin
        found <= 1'b1;
        best  <= cand;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (cmd.step && cnt_lt_n) begin
      cand <= epoch_table[cnt[IDX_W-1:0]];
      eqv  <= eq_now;
    end
    if (cmd.start) begin
      idx <= in_idx;
    end
  end

  assign sts.scan_end = !cnt_lt_n && !p_valid;

  // output register: read_epoch, quorum_found, quorum_epoch, padding
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word <= {(OUT_W - 2*EPOCH_W - 1)'(0), best, found, epoch_table[idx]};
    end
  end

endmodule
`default_nettype wire

### sv/reqt_ctrl.sv
`default_nettype none
module reqt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire reqt_pkg::reqt_sts_t  sts,
  output      reqt_pkg::reqt_cmd_t  cmd
);
  import reqt_pkg::*;

  reqt_state_t state, state_next;
  logic        out_valid, out_valid_next;
  logic        slot_free;

  // output slot frees when empty or its word is taken this cycle
  assign slot_free = !out_valid || m_tready;
  assign m_tvalid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    s_tready       = 1'b0;
    out_valid_next = out_valid && !m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          if (slot_free) begin
            cmd.load_out   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/replica_epoch_quorum_table_unit.sv
// Replica epoch quorum table.
// Slave stream carries one command word: write an epoch for a replica or
// read one back. Every accepted word yields exactly one master word with
// the addressed entry (after the write) and the quorum state: the smallest
// epoch held by at least 2*fault_count+1 of the first replica_count entries.
// Configuration (replica_count, fault_count, read_only) is to be written
// through cfg_we/cfg_index/cfg_data only while no command is in flight; the
// user is bound by this, as the block itself does not enforce it.
// The quorum scan issues one candidate entry per cycle over the first
// n = min(replica_count, 16) entries, compared against all table entries in
// parallel, followed by one fold stage; the next command is taken the cycle
// after the result is loaded, so commands never overlap.
// Reset clears all table entries to zero and restores the register defaults.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and its scan runs, then waits for the slot.
`default_nettype none
module replica_epoch_quorum_table_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [reqt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [reqt_pkg::CFG_W-1:0]     cfg_data,
  // command stream
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [reqt_pkg::IN_W-1:0]      s_tdata,  // command, replica_index, epoch_value
  // result stream
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [reqt_pkg::OUT_W-1:0]     m_tdata   // read_epoch, quorum_found, quorum_epoch
);
  import reqt_pkg::*;

  reqt_cmd_t cmd;
  reqt_sts_t sts;

  reqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  reqt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (m_tdata)
  );

endmodule
`default_nettype wire

### sv/reqt_chk.sv
`default_nettype none
module reqt_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [reqt_pkg::OUT_W-1:0] m_tdata
);
  import reqt_pkg::*;

  // one command at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a command while previous scan still running");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  // no quorum means quorum epoch reads zero
  a_no_quorum_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[EPOCH_W] |-> m_tdata[2*EPOCH_W:EPOCH_W+1] == '0)
    else $error("quorum epoch nonzero without quorum");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:2*EPOCH_W+1] == '0)
    else $error("result padding not zero");

endmodule

bind replica_epoch_quorum_table_unit reqt_chk u_reqt_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
